// ===== rtl/mer_pkg.sv =====
// Shared types, codes and constants of the midpoint ellipse rasterizer.
package mer_pkg;

	localparam int PIX_W = 12;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [1:0]       quad_t;

	// Quadrant codes, in emission order
	localparam quad_t QUAD_RED    = 2'd0;
	localparam quad_t QUAD_GREEN  = 2'd1;
	localparam quad_t QUAD_BLUE   = 2'd2;
	localparam quad_t QUAD_YELLOW = 2'd3;

	// Item action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	typedef enum logic [2:0] {
		MUL_RX_RX,
		MUL_RY_RY,
		MUL_RX2_RY,
		MUL_YM_YM,
		MUL_TX_TX,
		MUL_RX2_SQ,
		MUL_RY2_SQ,
		MUL_RX2_RY2
	} mul_sel_t;

	typedef enum logic [2:0] {
		DEC_HOLD,
		DEC_INIT,
		DEC_LOAD_4P,
		DEC_ADD_P,
		DEC_SUB_4P,
		DEC_STEP
	} dec_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_RX2_RY,
		ST_INIT,
		ST_SW_YM,
		ST_SW_TX,
		ST_SW_RX2,
		ST_SW_RY2,
		ST_SW_RXY,
		ST_SW_DONE,
		ST_R2_ENTER,
		ST_DEC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		dec_op_t  dec_op;
		logic     load_start;
		logic     load_rx2;
		logic     load_ry2;
		logic     load_sq;
		logic     step_terms;
		logic     step_x;
		logic     step_y;
		logic     region_two;
		logic     out_load;
		quad_t    out_quad;
	} mer_cmd_t;

	typedef struct packed {
		logic tx_lt_ty;
		logic dec_neg;
		logic dec_zero;
		logic oy_zero;
	} mer_stat_t;

endpackage

// ===== rtl/mer_item_if.sv =====
// Input channel: one ellipse command word per handshake.
interface mer_item_if #(parameter int COORD_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [COORD_BITS-1:0] center_x;
	logic [COORD_BITS-1:0] center_y;
	logic [COORD_BITS-1:0] radius_x;
	logic [COORD_BITS-1:0] radius_y;

	modport source (
		output valid, action, center_x, center_y, radius_x, radius_y,
		input  ready
	);
	modport sink (
		input  valid, action, center_x, center_y, radius_x, radius_y,
		output ready
	);
endinterface

// ===== rtl/mer_pixel_if.sv =====
// Output channel: one plotted pixel word per handshake.
interface mer_pixel_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mer_pkg::PIX_W-1:0]     pixel_x;
	logic signed [mer_pkg::PIX_W-1:0]     pixel_y;
	mer_pkg::quad_t                       quadrant_color;
	logic                                 last_of_point;
	logic                                 curve_done;

	modport source (
		output valid, pixel_x, pixel_y, quadrant_color, last_of_point, curve_done,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, quadrant_color, last_of_point, curve_done,
		output ready
	);
endinterface

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
// Sequence: a start word passes SQ_X, SQ_Y, RX2_RY and INIT before its first pixel word;
// a region-one step passes DEC; the crossing into region two runs the five-multiply setup.
// Throughput: one item at a time; four pixel words per point at one a cycle while the sink
// is ready, the next item taken the cycle after the fourth word leaves.
// Reset: arst_n clears the state machine, busy and region flags; held terms are loaded on start.
module midpoint_ellipse_rasterizer #(
	parameter int COORD_BITS = 10
) (
	input logic        clk,
	input logic        arst_n,
	mer_item_if.sink   item,
	mer_pixel_if.source pixel
);

	mer_pkg::mer_cmd_t  cmd;
	mer_pkg::mer_stat_t stat;

	// Controller: sequences setup multiplies, decision updates and the four
	// quadrant words of each point; owns both handshakes.
	mer_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_ready  (item.ready),
		.item_action (item.action),
		.pixel_valid (pixel.valid),
		.pixel_ready (pixel.ready),
		.cmd         (cmd),
		.stat        (stat)
	);

	// Datapath: holds the center, squared radii, offsets, step terms and the
	// decision value (four times the textbook value, exact integer); drives
	// the registered pixel word.
	mer_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.stat           (stat),
		.center_x       (item.center_x),
		.center_y       (item.center_y),
		.radius_x       (item.radius_x),
		.radius_y       (item.radius_y),
		.pixel_x        (pixel.pixel_x),
		.pixel_y        (pixel.pixel_y),
		.quadrant_color (pixel.quadrant_color),
		.last_of_point  (pixel.last_of_point),
		.curve_done     (pixel.curve_done)
	);

endmodule

// ===== rtl/mer_ctrl.sv =====
// Controller state machine of the midpoint ellipse rasterizer.
module mer_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               item_action,
	output logic               pixel_valid,
	input  logic               pixel_ready,
	output mer_pkg::mer_cmd_t  cmd,
	input  mer_pkg::mer_stat_t stat
);

	mer_pkg::state_t state_q, state_d;
	logic            busy_q;
	logic            r2_q;
	mer_pkg::quad_t  quad_q;

	logic busy_set, busy_clr, r2_set, r2_clr, quad_clr, quad_inc;
	logic item_acc;

	assign item_acc = item_valid & item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_IDLE;
			busy_q  <= 1'b0;
			r2_q    <= 1'b0;
			quad_q  <= mer_pkg::QUAD_RED;
		end else begin
			state_q <= state_d;
			if (busy_set)
				busy_q <= 1'b1;
			else if (busy_clr)
				busy_q <= 1'b0;
			if (r2_set)
				r2_q <= 1'b1;
			else if (r2_clr)
				r2_q <= 1'b0;
			if (quad_clr)
				quad_q <= mer_pkg::QUAD_RED;
			else if (quad_inc)
				quad_q <= quad_q + 2'd1;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mer_pkg::ST_IDLE: begin
				if (item_acc) begin
					if (item_action == mer_pkg::ACT_START)
						state_d = mer_pkg::ST_SQ_X;
					else if (busy_q && !r2_q && stat.tx_lt_ty)
						state_d = mer_pkg::ST_DEC;
					else if (busy_q && !r2_q)
						state_d = mer_pkg::ST_SW_YM;
					else if (busy_q && !stat.oy_zero)
						state_d = mer_pkg::ST_DEC;
				end
			end
			mer_pkg::ST_SQ_X:    state_d = mer_pkg::ST_SQ_Y;
			mer_pkg::ST_SQ_Y:    state_d = mer_pkg::ST_RX2_RY;
			mer_pkg::ST_RX2_RY:  state_d = mer_pkg::ST_INIT;
			mer_pkg::ST_INIT:    state_d = mer_pkg::ST_EMIT;
			mer_pkg::ST_SW_YM:   state_d = mer_pkg::ST_SW_TX;
			mer_pkg::ST_SW_TX:   state_d = mer_pkg::ST_SW_RX2;
			mer_pkg::ST_SW_RX2:  state_d = mer_pkg::ST_SW_RY2;
			mer_pkg::ST_SW_RY2:  state_d = mer_pkg::ST_SW_RXY;
			mer_pkg::ST_SW_RXY:  state_d = mer_pkg::ST_SW_DONE;
			mer_pkg::ST_SW_DONE: state_d = mer_pkg::ST_R2_ENTER;
			mer_pkg::ST_R2_ENTER: begin
				if (stat.oy_zero)
					state_d = mer_pkg::ST_IDLE;
				else
					state_d = mer_pkg::ST_DEC;
			end
			mer_pkg::ST_DEC:     state_d = mer_pkg::ST_EMIT;
			mer_pkg::ST_EMIT: begin
				if (pixel_ready && quad_q == mer_pkg::QUAD_YELLOW)
					state_d = mer_pkg::ST_IDLE;
			end
			default:             state_d = mer_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd            = '0;
		cmd.mul_sel    = mer_pkg::MUL_RX_RX;
		cmd.dec_op     = mer_pkg::DEC_HOLD;
		cmd.out_quad   = mer_pkg::QUAD_RED;
		cmd.region_two = r2_q;
		item_ready     = 1'b0;
		pixel_valid    = 1'b0;
		busy_set       = 1'b0;
		busy_clr       = 1'b0;
		r2_set         = 1'b0;
		r2_clr         = 1'b0;
		quad_clr       = 1'b0;
		quad_inc       = 1'b0;
		case (state_q)
			mer_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_action == mer_pkg::ACT_START) begin
						cmd.load_start = 1'b1;
						busy_set       = 1'b1;
						r2_clr         = 1'b1;
					end else if (busy_q && !r2_q && stat.tx_lt_ty) begin
						// region one: x always advances, y on a nonnegative decision
						cmd.step_terms = 1'b1;
						cmd.step_x     = 1'b1;
						cmd.step_y     = !stat.dec_neg;
					end else if (busy_q && r2_q) begin
						if (stat.oy_zero) begin
							busy_clr = 1'b1;
						end else begin
							cmd.step_terms = 1'b1;
							cmd.step_x     = stat.dec_neg | stat.dec_zero;
							cmd.step_y     = 1'b1;
						end
					end
				end
			end
			mer_pkg::ST_SQ_X: begin
				cmd.mul_sel = mer_pkg::MUL_RX_RX;
			end
			mer_pkg::ST_SQ_Y: begin
				cmd.load_rx2 = 1'b1;
				cmd.mul_sel  = mer_pkg::MUL_RY_RY;
			end
			mer_pkg::ST_RX2_RY: begin
				cmd.load_ry2 = 1'b1;
				cmd.mul_sel  = mer_pkg::MUL_RX2_RY;
			end
			mer_pkg::ST_INIT: begin
				cmd.dec_op   = mer_pkg::DEC_INIT;
				cmd.out_load = 1'b1;
				quad_clr     = 1'b1;
			end
			mer_pkg::ST_SW_YM: begin
				cmd.mul_sel = mer_pkg::MUL_YM_YM;
			end
			mer_pkg::ST_SW_TX: begin
				cmd.load_sq = 1'b1;
				cmd.mul_sel = mer_pkg::MUL_TX_TX;
			end
			mer_pkg::ST_SW_RX2: begin
				cmd.load_sq = 1'b1;
				cmd.mul_sel = mer_pkg::MUL_RX2_SQ;
			end
			mer_pkg::ST_SW_RY2: begin
				cmd.dec_op  = mer_pkg::DEC_LOAD_4P;
				cmd.mul_sel = mer_pkg::MUL_RY2_SQ;
			end
			mer_pkg::ST_SW_RXY: begin
				cmd.dec_op  = mer_pkg::DEC_ADD_P;
				cmd.mul_sel = mer_pkg::MUL_RX2_RY2;
			end
			mer_pkg::ST_SW_DONE: begin
				cmd.dec_op = mer_pkg::DEC_SUB_4P;
				r2_set     = 1'b1;
			end
			mer_pkg::ST_R2_ENTER: begin
				if (stat.oy_zero) begin
					busy_clr = 1'b1;
				end else begin
					cmd.step_terms = 1'b1;
					cmd.step_x     = stat.dec_neg | stat.dec_zero;
					cmd.step_y     = 1'b1;
				end
			end
			mer_pkg::ST_DEC: begin
				cmd.dec_op   = mer_pkg::DEC_STEP;
				cmd.out_load = 1'b1;
				quad_clr     = 1'b1;
			end
			mer_pkg::ST_EMIT: begin
				pixel_valid = 1'b1;
				if (pixel_ready) begin
					if (quad_q == mer_pkg::QUAD_YELLOW) begin
						if (stat.oy_zero)
							busy_clr = 1'b1;
					end else begin
						cmd.out_load = 1'b1;
						cmd.out_quad = quad_q + 2'd1;
						quad_inc     = 1'b1;
					end
				end
			end
			default: begin
				cmd.dec_op = mer_pkg::DEC_HOLD;
			end
		endcase
	end

endmodule

// ===== rtl/mer_datapath.sv =====
// Datapath: held ellipse terms, shared multiplier, decision value and pixel register.
module mer_datapath #(
	parameter int COORD_BITS = 10
) (
	input  logic                             clk,
	input  mer_pkg::mer_cmd_t                cmd,
	output mer_pkg::mer_stat_t               stat,
	input  logic [COORD_BITS-1:0]            center_x,
	input  logic [COORD_BITS-1:0]            center_y,
	input  logic [COORD_BITS-1:0]            radius_x,
	input  logic [COORD_BITS-1:0]            radius_y,
	output logic signed [mer_pkg::PIX_W-1:0] pixel_x,
	output logic signed [mer_pkg::PIX_W-1:0] pixel_y,
	output mer_pkg::quad_t                   quadrant_color,
	output logic                             last_of_point,
	output logic                             curve_done
);

	localparam int CW  = COORD_BITS;
	localparam int OXW = CW + 1;
	localparam int TXW = CW + 2;
	localparam int AW  = 2 * CW;
	localparam int BW  = 2 * CW + 4;
	localparam int PW  = AW + BW;
	localparam int SW  = 3 * CW + 3;
	localparam int DW  = (4 * CW + 6 > 64) ? 64 : 4 * CW + 6;

	logic [CW-1:0]  cx_q, cy_q, rx_q, oy_q;
	logic [OXW-1:0] ox_q;
	logic [AW-1:0]  rx2_q, ry2_q;
	logic [BW-1:0]  sq_q;
	logic [PW-1:0]  p_q;
	logic [SW-1:0]  tx_q, ty_q;
	logic [DW-1:0]  dec_q;
	logic           step_x_q, step_y_q;

	logic [TXW-1:0] txv;
	logic [CW-1:0]  ymv;
	logic [AW-1:0]  mul_a;
	logic [BW-1:0]  mul_b;
	logic [DW-1:0]  p_d, rx2_d, ry2_d, tx_d, ty_d, rr_d, add_tx, sub_ty;
	mer_pkg::pix_t  xp, xm, yp, ym;

	assign stat.tx_lt_ty = tx_q < ty_q;
	assign stat.dec_neg  = dec_q[DW-1];
	assign stat.dec_zero = dec_q == '0;
	assign stat.oy_zero  = oy_q == '0;

	// (2x+1) and |y-1| for the region-two setup
	assign txv = {ox_q, 1'b1};
	assign ymv = stat.oy_zero ? CW'(1) : oy_q - CW'(1);

	always_comb begin
		case (cmd.mul_sel)
			mer_pkg::MUL_RX_RX: begin
				mul_a = AW'(rx_q);
				mul_b = BW'(rx_q);
			end
			mer_pkg::MUL_RY_RY: begin
				mul_a = AW'(oy_q);
				mul_b = BW'(oy_q);
			end
			mer_pkg::MUL_RX2_RY: begin
				mul_a = rx2_q;
				mul_b = BW'(oy_q);
			end
			mer_pkg::MUL_YM_YM: begin
				mul_a = AW'(ymv);
				mul_b = BW'(ymv);
			end
			mer_pkg::MUL_TX_TX: begin
				mul_a = AW'(txv);
				mul_b = BW'(txv);
			end
			mer_pkg::MUL_RX2_SQ: begin
				mul_a = rx2_q;
				mul_b = sq_q;
			end
			mer_pkg::MUL_RY2_SQ: begin
				mul_a = ry2_q;
				mul_b = sq_q;
			end
			mer_pkg::MUL_RX2_RY2: begin
				mul_a = rx2_q;
				mul_b = BW'(ry2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign p_d    = DW'(p_q);
	assign rx2_d  = DW'(rx2_q);
	assign ry2_d  = DW'(ry2_q);
	assign tx_d   = DW'(tx_q);
	assign ty_d   = DW'(ty_q);
	assign rr_d   = cmd.region_two ? rx2_d : ry2_d;
	assign add_tx = step_x_q ? (tx_d << 2) : '0;
	assign sub_ty = step_y_q ? (ty_d << 2) : '0;

	always_ff @(posedge clk) begin
		p_q <= PW'(mul_a) * PW'(mul_b);

		if (cmd.load_start) begin
			cx_q <= center_x;
			cy_q <= center_y;
			rx_q <= radius_x;
			ox_q <= '0;
			oy_q <= radius_y;
			tx_q <= '0;
		end
		if (cmd.load_rx2)
			rx2_q <= AW'(p_q);
		if (cmd.load_ry2)
			ry2_q <= AW'(p_q);
		if (cmd.load_sq)
			sq_q <= BW'(p_q);

		if (cmd.step_terms) begin
			step_x_q <= cmd.step_x;
			step_y_q <= cmd.step_y;
			if (cmd.step_x) begin
				ox_q <= ox_q + OXW'(1);
				tx_q <= tx_q + SW'({ry2_q, 1'b0});
			end
			if (cmd.step_y) begin
				oy_q <= oy_q - CW'(1);
				ty_q <= ty_q - SW'({rx2_q, 1'b0});
			end
		end

		case (cmd.dec_op)
			mer_pkg::DEC_INIT: begin
				ty_q  <= SW'({p_q, 1'b0});
				dec_q <= (ry2_d << 2) - (p_d << 2) + rx2_d;
			end
			mer_pkg::DEC_LOAD_4P: dec_q <= p_d << 2;
			mer_pkg::DEC_ADD_P:   dec_q <= dec_q + p_d;
			mer_pkg::DEC_SUB_4P:  dec_q <= dec_q - (p_d << 2);
			mer_pkg::DEC_STEP:    dec_q <= dec_q + (rr_d << 2) + add_tx - sub_ty;
			default:              dec_q <= dec_q;
		endcase
	end

	// Symmetric coordinates, wrapped to the pixel field
	assign xp = mer_pkg::pix_t'(cx_q) + mer_pkg::pix_t'(ox_q);
	assign xm = mer_pkg::pix_t'(cx_q) - mer_pkg::pix_t'(ox_q);
	assign yp = mer_pkg::pix_t'(cy_q) + mer_pkg::pix_t'(oy_q);
	assign ym = mer_pkg::pix_t'(cy_q) - mer_pkg::pix_t'(oy_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_quad)
				mer_pkg::QUAD_RED: begin
					pixel_x <= xp;
					pixel_y <= yp;
				end
				mer_pkg::QUAD_GREEN: begin
					pixel_x <= xm;
					pixel_y <= yp;
				end
				mer_pkg::QUAD_BLUE: begin
					pixel_x <= xp;
					pixel_y <= ym;
				end
				default: begin
					pixel_x <= xm;
					pixel_y <= ym;
				end
			endcase
			quadrant_color <= cmd.out_quad;
			last_of_point  <= cmd.out_quad == mer_pkg::QUAD_YELLOW;
			curve_done     <= stat.oy_zero;
		end
	end

endmodule
